FILE: design/asg_pkg.sv
package asg_pkg;

    localparam int GROUP_W       = 11;
    localparam int RANK_W        = 10;
    localparam int COUNT_W       = 31;
    localparam int ESIZE_W       = 9;
    localparam int SMB_W         = 32;
    localparam int LOG_W         = $clog2(GROUP_W);
    localparam int PROD_W        = COUNT_W + ESIZE_W;
    localparam int DEF_MAX_RANKS = 1024;
    localparam int MAX_RESULTS   = 20;
    localparam int OPS_W         = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int ADDR_W        = 3;
    localparam int APB_W         = 32;
    localparam int IN_W          = 56;
    localparam int OUT_W         = 72;
    localparam int USER_W        = 2;

    localparam logic [GROUP_W-1:0] GROUP_RESET = GROUP_W'(1);
    localparam logic [SMB_W-1:0]   SMB_RESET   = SMB_W'(2048);

    typedef enum logic [0:0] {
        REG_GROUP_SIZE = 1'b0,
        REG_SHORT_MSG  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_RECV = 2'd1,
        OP_XCHG = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [COUNT_W-1:0] count;
        logic               fold;
        logic               use_rd;
        logic [GROUP_W-1:0] nr;
        logic [GROUP_W-1:0] rem;
        logic [GROUP_W-1:0] p;
        logic [COUNT_W-1:0] q;
        logic [GROUP_W-1:0] r;
    } desc_t;

endpackage

FILE: design/allreduce_schedule_generator_unit.sv
// Allreduce schedule generator. Each request (own rank, element count, element size) on the
// input stream becomes the point-to-point operations that rank performs in an allreduce over
// the configured group: the fold-in of the non-power-of-two ranks, then recursive doubling or
// a reduce-scatter plus allgather, then the fold-out. Each operation leaves as one output
// transfer, tlast on the final one; a rank outside the group or a group of one gives none.
// Registers: group_size at 0x0, short_message_bytes at 0x4; write them only while idle.
// Flow: the front end takes a request only while idle, registers it, computes its descriptor
// and hands it to a two-entry queue, waiting while the queue is full; the back-end sequencer
// loads a descriptor from the queue and then issues one operation per cycle while the output
// is not stalled, at most 20 per request, each passing through the length, multiply and
// output registers.
module allreduce_schedule_generator_unit
    import asg_pkg::*;
#(
    parameter int MAX_RANKS = DEF_MAX_RANKS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // own_rank[9:0], element_count[40:10], element_bytes[49:41], zero fill
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // peer[9:0], send_elements[40:10], recv_elements[71:41]
    output logic [OUT_W-1:0]  m_axis_tdata,
    // op_kind[1:0]
    output logic [USER_W-1:0] m_axis_tuser,
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [GROUP_W-1:0] group_reg;
    logic [SMB_W-1:0]   smb_reg;
    reg_idx_t           reg_idx;

    logic               push;
    desc_t              push_desc;
    logic               q_full;
    logic               pop;
    desc_t              head;
    logic               q_empty;

    logic [RANK_W-1:0]  peer;
    logic [COUNT_W-1:0] send_elements;
    logic [COUNT_W-1:0] recv_elements;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= GROUP_RESET;
            smb_reg   <= SMB_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_GROUP_SIZE: group_reg <= pwdata[GROUP_W-1:0];
                REG_SHORT_MSG:  smb_reg   <= pwdata[SMB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GROUP_SIZE: prdata = APB_W'(group_reg);
            REG_SHORT_MSG:  prdata = APB_W'(smb_reg);
            default:        prdata = '0;
        endcase
    end

    asg_front #(
        .MAX_RANKS(MAX_RANKS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .own_rank           (s_axis_tdata[9:0]),
        .element_count      (s_axis_tdata[40:10]),
        .element_bytes      (s_axis_tdata[49:41]),
        .group_size         (group_reg),
        .short_message_bytes(smb_reg),
        .push               (push),
        .push_desc          (push_desc),
        .q_full             (q_full)
    );

    asg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_desc(push_desc),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    asg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop          (pop),
        .head         (head),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .op_kind      (m_axis_tuser),
        .peer         (peer),
        .send_elements(send_elements),
        .recv_elements(recv_elements),
        .last_op      (m_axis_tlast)
    );

    assign m_axis_tdata = {recv_elements, send_elements, peer};

endmodule

FILE: design/asg_front.sv
module asg_front
    import asg_pkg::*;
#(
    parameter int MAX_RANKS = DEF_MAX_RANKS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [RANK_W-1:0]  own_rank,
    input  logic [COUNT_W-1:0] element_count,
    input  logic [ESIZE_W-1:0] element_bytes,
    input  logic [GROUP_W-1:0] group_size,
    input  logic [SMB_W-1:0]   short_message_bytes,
    output logic               push,
    output desc_t              push_desc,
    input  logic               q_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } fstate_t;

    fstate_t            state_reg;
    fstate_t            state_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ESIZE_W-1:0] esize_reg;
    desc_t              desc_reg;
    logic               drop_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               lt_reg;

    logic [GROUP_W-1:0] g_eff;
    logic [LOG_W-1:0]   lp;
    logic [GROUP_W-1:0] p_val;
    logic [GROUP_W-1:0] rem_val;
    logic               fold;
    desc_t              calc_desc;
    logic               drop;
    logic [PROD_W-1:0]  prod;
    logic               lt;

    always_comb
    begin
        g_eff = (group_size == '0) ? GROUP_W'(1) : group_size;
        if (32'(g_eff) > 32'(MAX_RANKS))
        begin
            g_eff = GROUP_W'(MAX_RANKS);
        end
        lp = '0;
        for (int i = 0; i < GROUP_W; i++)
        begin
            if (g_eff[i])
            begin
                lp = LOG_W'(i);
            end
        end
        p_val   = GROUP_W'(1) << lp;
        rem_val = g_eff - p_val;
        fold    = {2'b0, rank_reg} < {rem_val, 1'b0};
        drop    = ({1'b0, rank_reg} >= g_eff) || (g_eff == GROUP_W'(1));
        prod    = PROD_W'(count_reg) * PROD_W'(esize_reg);
        lt      = count_reg < COUNT_W'(p_val);

        calc_desc.rank   = rank_reg;
        calc_desc.count  = count_reg;
        calc_desc.fold   = fold;
        calc_desc.use_rd = 1'b0;
        calc_desc.nr     = fold ? {2'b0, rank_reg[RANK_W-1:1]} : ({1'b0, rank_reg} - rem_val);
        calc_desc.rem    = rem_val;
        calc_desc.p      = p_val;
        calc_desc.q      = count_reg >> lp;
        calc_desc.r      = count_reg[GROUP_W-1:0] & (p_val - GROUP_W'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (drop_reg || !q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_desc        = desc_reg;
        push_desc.use_rd = (prod_reg <= PROD_W'(short_message_bytes)) || lt_reg;
    end

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !drop_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        rank_reg  <= own_rank;
                        count_reg <= element_count;
                        esize_reg <= element_bytes;
                    end
                end
                F_CALC:
                begin
                    desc_reg <= calc_desc;
                    drop_reg <= drop;
                    prod_reg <= prod;
                    lt_reg   <= lt;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: design/asg_queue.sv
module asg_queue
    import asg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output desc_t head,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= push_desc;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/asg_back.sv
module asg_back
    import asg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               pop,
    input  desc_t              head,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         op_kind,
    output logic [RANK_W-1:0]  peer,
    output logic [COUNT_W-1:0] send_elements,
    output logic [COUNT_W-1:0] recv_elements,
    output logic               last_op
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_PRE,
        B_RD,
        B_RS,
        B_AG,
        B_POST
    } bstate_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [RANK_W-1:0]  peer;
        logic [GROUP_W-1:0] len_s;
        logic [GROUP_W-1:0] len_r;
        logic               tail_s;
        logic               tail_r;
        logic [COUNT_W-1:0] mult;
        logic [GROUP_W-1:0] r;
        logic               last;
    } lens_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [RANK_W-1:0]  peer;
        logic [COUNT_W-1:0] prod_s;
        logic [COUNT_W-1:0] prod_r;
        logic               tail_s;
        logic               tail_r;
        logic [GROUP_W-1:0] r;
        logic               last;
    } prods_t;

    localparam int MUL_W = GROUP_W + COUNT_W;

    bstate_t            state_reg;
    bstate_t            state_next;
    desc_t              job_reg;
    logic [GROUP_W-1:0] mask_reg;
    logic [GROUP_W-1:0] mask_next;
    logic [GROUP_W-1:0] hm_reg;
    logic [GROUP_W-1:0] hm_next;
    logic [GROUP_W-1:0] si_reg;
    logic [GROUP_W-1:0] si_next;
    logic [GROUP_W-1:0] ri_reg;
    logic [GROUP_W-1:0] ri_next;
    logic [GROUP_W-1:0] li_reg;
    logic [GROUP_W-1:0] li_next;
    logic [OPS_W-1:0]   nops_reg;
    logic [OPS_W-1:0]   nops_next;

    logic               a_valid_reg;
    lens_t              a_reg;
    lens_t              a_next;
    logic               b_valid_reg;
    prods_t             b_reg;
    logic               o_valid_reg;
    op_kind_t           o_kind_reg;
    logic [RANK_W-1:0]  o_peer_reg;
    logic [COUNT_W-1:0] o_send_reg;
    logic [COUNT_W-1:0] o_recv_reg;
    logic               o_last_reg;

    logic               out_free;
    logic               b_free;
    logic               a_free;
    logic               step;
    logic               even;
    logic               up;
    logic               nat_last;
    logic [GROUP_W-1:0] sa;
    logic [GROUP_W-1:0] sb;
    logic [GROUP_W-1:0] ra;
    logic [GROUP_W-1:0] rb;
    logic [GROUP_W-1:0] tmp;
    logic [GROUP_W-1:0] li_up;
    logic [MUL_W-1:0]   full_s;
    logic [MUL_W-1:0]   full_r;

    function automatic logic [RANK_W-1:0] real_rank(input logic [GROUP_W-1:0] nd,
                                                   input logic [GROUP_W-1:0] rem);
        logic [GROUP_W:0] rr;
        if (nd < rem)
        begin
            rr = {nd, 1'b1};
        end
        else
        begin
            rr = {1'b0, nd} + {1'b0, rem};
        end
        return rr[RANK_W-1:0];
    endfunction

    assign out_free = !o_valid_reg || out_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign step     = (state_reg != B_IDLE) && a_free;
    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign even     = !job_reg.rank[0];
    assign up       = ((job_reg.nr & mask_reg) == '0);

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        hm_next    = hm_reg;
        si_next    = si_reg;
        ri_next    = ri_reg;
        li_next    = li_reg;
        nops_next  = nops_reg;
        nat_last   = 1'b0;
        sa         = '0;
        sb         = '0;
        ra         = '0;
        rb         = '0;
        tmp        = '0;
        li_up      = li_reg;
        a_next.kind = OP_XCHG;
        a_next.peer = real_rank(job_reg.nr ^ mask_reg, job_reg.rem);
        a_next.mult = job_reg.count;
        a_next.r    = job_reg.r;

        if (pop)
        begin
            mask_next  = GROUP_W'(1);
            hm_next    = head.p >> 1;
            si_next    = '0;
            ri_next    = '0;
            li_next    = head.p;
            nops_next  = '0;
            state_next = head.fold ? B_PRE : (head.use_rd ? B_RD : B_RS);
        end
        else if (step)
        begin
            unique case (state_reg)
                B_PRE:
                begin
                    a_next.kind = even ? OP_SEND : OP_RECV;
                    a_next.peer = even ? job_reg.rank + RANK_W'(1) : job_reg.rank - RANK_W'(1);
                    sb = even ? GROUP_W'(1) : '0;
                    rb = even ? '0 : GROUP_W'(1);
                    state_next = even ? B_POST : (job_reg.use_rd ? B_RD : B_RS);
                end
                B_RD:
                begin
                    sb = GROUP_W'(1);
                    rb = GROUP_W'(1);
                    nat_last = !job_reg.fold && (hm_reg == GROUP_W'(1));
                    if (hm_reg == GROUP_W'(1))
                    begin
                        state_next = job_reg.fold ? B_POST : B_IDLE;
                    end
                    else
                    begin
                        mask_next = mask_reg << 1;
                        hm_next   = hm_reg >> 1;
                    end
                end
                B_RS:
                begin
                    a_next.mult = job_reg.q;
                    if (up)
                    begin
                        tmp = ri_reg + hm_reg;
                        sa  = tmp;
                        sb  = li_reg;
                        ra  = ri_reg;
                        rb  = tmp;
                        tmp = ri_reg;
                    end
                    else
                    begin
                        tmp = si_reg + hm_reg;
                        sa  = si_reg;
                        sb  = tmp;
                        ra  = tmp;
                        rb  = li_reg;
                    end
                    si_next = tmp;
                    ri_next = tmp;
                    if (hm_reg == GROUP_W'(1))
                    begin
                        state_next = B_AG;
                    end
                    else
                    begin
                        li_next   = tmp + hm_reg;
                        mask_next = mask_reg << 1;
                        hm_next   = hm_reg >> 1;
                    end
                end
                B_AG:
                begin
                    a_next.mult = job_reg.q;
                    if (up)
                    begin
                        if (mask_reg != (job_reg.p >> 1))
                        begin
                            li_up = li_reg + hm_reg;
                        end
                        tmp = si_reg + hm_reg;
                        sa  = si_reg;
                        sb  = tmp;
                        ra  = tmp;
                        rb  = li_up;
                        li_next = li_up;
                        ri_next = tmp;
                    end
                    else
                    begin
                        tmp = si_reg - hm_reg;
                        sa  = si_reg;
                        sb  = li_reg;
                        ra  = tmp;
                        rb  = si_reg;
                        ri_next = tmp;
                        si_next = tmp;
                    end
                    nat_last = !job_reg.fold && (mask_reg == GROUP_W'(1));
                    if (mask_reg == GROUP_W'(1))
                    begin
                        state_next = job_reg.fold ? B_POST : B_IDLE;
                    end
                    else
                    begin
                        mask_next = mask_reg >> 1;
                        hm_next   = hm_reg << 1;
                    end
                end
                B_POST:
                begin
                    a_next.kind = even ? OP_RECV : OP_SEND;
                    a_next.peer = even ? job_reg.rank + RANK_W'(1) : job_reg.rank - RANK_W'(1);
                    sb = even ? '0 : GROUP_W'(1);
                    rb = even ? GROUP_W'(1) : '0;
                    nat_last   = 1'b1;
                    state_next = B_IDLE;
                end
                default:
                begin
                end
            endcase
            nops_next = nops_reg + 1'b1;
        end

        a_next.last   = nat_last || (nops_reg == OPS_W'(MAX_RESULTS - 1));
        a_next.len_s  = (sb > sa) ? sb - sa : '0;
        a_next.len_r  = (rb > ra) ? rb - ra : '0;
        a_next.tail_s = (sb > sa) && (sb == job_reg.p);
        a_next.tail_r = (rb > ra) && (rb == job_reg.p);
        if (step && a_next.last)
        begin
            state_next = B_IDLE;
        end
    end

    assign full_s = MUL_W'(a_reg.len_s) * MUL_W'(a_reg.mult);
    assign full_r = MUL_W'(a_reg.len_r) * MUL_W'(a_reg.mult);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            hm_reg    <= hm_next;
            si_reg    <= si_next;
            ri_reg    <= ri_next;
            li_reg    <= li_next;
            nops_reg  <= nops_next;
            if (pop)
            begin
                job_reg <= head;
            end
            if (a_free)
            begin
                a_valid_reg <= step;
                if (step)
                begin
                    a_reg <= a_next;
                end
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
                if (a_valid_reg)
                begin
                    b_reg.kind   <= a_reg.kind;
                    b_reg.peer   <= a_reg.peer;
                    b_reg.prod_s <= full_s[COUNT_W-1:0];
                    b_reg.prod_r <= full_r[COUNT_W-1:0];
                    b_reg.tail_s <= a_reg.tail_s;
                    b_reg.tail_r <= a_reg.tail_r;
                    b_reg.r      <= a_reg.r;
                    b_reg.last   <= a_reg.last;
                end
            end
            if (out_free)
            begin
                o_valid_reg <= b_valid_reg;
                if (b_valid_reg)
                begin
                    o_kind_reg <= b_reg.kind;
                    o_peer_reg <= b_reg.peer;
                    o_send_reg <= b_reg.prod_s + (b_reg.tail_s ? COUNT_W'(b_reg.r) : '0);
                    o_recv_reg <= b_reg.prod_r + (b_reg.tail_r ? COUNT_W'(b_reg.r) : '0);
                    o_last_reg <= b_reg.last;
                end
            end
        end
    end

    assign out_valid     = o_valid_reg;
    assign op_kind       = o_kind_reg;
    assign peer          = o_peer_reg;
    assign send_elements = o_send_reg;
    assign recv_elements = o_recv_reg;
    assign last_op       = o_last_reg;

endmodule

FILE: design/asg_checker.sv
module asg_checker
    import asg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [USER_W-1:0] m_axis_tuser,
    input logic              m_axis_tlast
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == OP_SEND) |-> (m_axis_tdata[71:41] == '0))
    else $error("send carries a receive count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == OP_RECV) |-> (m_axis_tdata[40:10] == '0))
    else $error("receive carries a send count");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken in back-to-back cycles");

endmodule

bind allreduce_schedule_generator_unit asg_checker u_asg_checker (.*);
